>>> rtl/tw_pkg.sv
`default_nettype none

package tw_pkg;

    // Phase accumulator and table geometry
    localparam int PHASE_BITS    = 32;
    localparam int SINE_DEPTH    = 1024;
    localparam int MAX_CHANNELS  = 8;
    localparam int OUT_LIMIT     = 8;
    localparam int CH_LIMIT      = (MAX_CHANNELS < OUT_LIMIT) ? MAX_CHANNELS : OUT_LIMIT;

    // Phase reduced to a 32-bit cycle fraction
    localparam int Q_SHR = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
    localparam int Q_SHL = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;

    // Field widths
    localparam int START_W   = 48;
    localparam int SAMPLE_W  = 16;
    localparam int CH_W      = 3;
    localparam int COUNT_W   = 4;
    localparam int GAIN_W    = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    // Datapath widths
    localparam int SINE_ADDR_W = $clog2(SINE_DEPTH + 1);
    localparam int ROM_W       = 17;
    localparam int WAVE_W      = 17;
    localparam int TRI_W       = 34;
    localparam int PROD_W      = 34;

    // Command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_AW + 1;

    // Register reset values
    localparam logic [CFG_W-1:0]   PHASE_INC_RESET = 32'd39370534;
    localparam logic [GAIN_W-1:0]  GAIN_RESET      = 16'd16384;
    localparam logic [COUNT_W-1:0] CHANNELS_RESET  = 4'd2;

    // Sine table generation
    localparam logic [63:0] PI_Q30   = 64'd3373259426;
    localparam logic [63:0] SINE_DIV = 64'(2 * SINE_DEPTH);

    typedef enum logic {
        REQ_SEEK = 1'b0,
        REQ_TICK = 1'b1
    } t_req_kind;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_TRIANGLE = 2'd2,
        WAVE_SAW      = 2'd3
    } t_wave;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_INC  = 2'd0,
        CFG_WAVEFORM   = 2'd1,
        CFG_LEVEL_GAIN = 2'd2,
        CFG_CHANNELS   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [PHASE_BITS-1:0] phase_inc;
        t_wave                 wave;
        logic [GAIN_W-1:0]     gain;
        logic [COUNT_W-1:0]    chan_count;
    } t_cfg;

    typedef struct packed {
        t_req_kind             kind;
        logic [PHASE_BITS-1:0] seek_phase;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [CH_W-1:0]            last_idx;
    } t_frame;

    typedef logic [ROM_W-1:0] t_sine_rom [0:SINE_DEPTH];

    // Quarter-wave entry: eleven-term Taylor series in Q30, rounded half up
    function automatic logic [ROM_W-1:0] sine_entry(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        t;
        logic [63:0]        e;
        logic signed [63:0] sum;
        x   = (PI_Q30 * 64'(k)) / SINE_DIV;
        t   = x;
        sum = signed'(x);
        t = (((t * x) >> 30) * x) >> 30;  t = t / 64'd6;    sum = sum - signed'(t);
        t = (((t * x) >> 30) * x) >> 30;  t = t / 64'd20;   sum = sum + signed'(t);
        t = (((t * x) >> 30) * x) >> 30;  t = t / 64'd42;   sum = sum - signed'(t);
        t = (((t * x) >> 30) * x) >> 30;  t = t / 64'd72;   sum = sum + signed'(t);
        t = (((t * x) >> 30) * x) >> 30;  t = t / 64'd110;  sum = sum - signed'(t);
        t = (((t * x) >> 30) * x) >> 30;  t = t / 64'd156;  sum = sum + signed'(t);
        t = (((t * x) >> 30) * x) >> 30;  t = t / 64'd210;  sum = sum - signed'(t);
        t = (((t * x) >> 30) * x) >> 30;  t = t / 64'd272;  sum = sum + signed'(t);
        t = (((t * x) >> 30) * x) >> 30;  t = t / 64'd342;  sum = sum - signed'(t);
        t = (((t * x) >> 30) * x) >> 30;  t = t / 64'd420;  sum = sum + signed'(t);
        if (sum < 0) begin
            sum = 64'sd0;
        end
        e = ((unsigned'(sum) * 64'd32768) + 64'd536870912) >> 30;
        if (e > 64'd32768) begin
            e = 64'd32768;
        end
        return ROM_W'(e);
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            rom[k] = sine_entry(k);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

>>> rtl/tw_in_if.sv
`default_nettype none

interface tw_in_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [tw_pkg::START_W-1:0]   start_sample;

    modport source (output valid, output req_type, output start_sample, input ready);
    modport sink   (input valid, input req_type, input start_sample, output ready);
endinterface

`default_nettype wire

>>> rtl/tw_out_if.sv
`default_nettype none

interface tw_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [tw_pkg::SAMPLE_W-1:0]  sample;
    logic [tw_pkg::CH_W-1:0]             channel;
    logic                                last_channel;

    modport source (output valid, output sample, output channel, output last_channel,
                    input ready);
    modport sink   (input valid, input sample, input channel, input last_channel,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/tw_front.sv
`default_nettype none

module tw_front (
    tw_in_if.sink                           i_in,
    input  wire logic [tw_pkg::PHASE_BITS-1:0] i_phase_inc,
    input  wire tw_pkg::t_q_status          i_qs,
    output logic                            o_push,
    output tw_pkg::t_cmd                    o_cmd
);

    logic [tw_pkg::PHASE_BITS-1:0] w_start_lo;

    // Only the low phase bits of the start index survive the wrap
    assign w_start_lo = tw_pkg::PHASE_BITS'(i_in.start_sample);

    assign i_in.ready       = !i_qs.full;
    assign o_push           = i_in.valid && !i_qs.full;
    assign o_cmd.kind       = tw_pkg::t_req_kind'(i_in.req_type);
    assign o_cmd.seek_phase = w_start_lo * i_phase_inc;

endmodule

`default_nettype wire

>>> rtl/tw_queue.sv
`default_nettype none

module tw_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tw_pkg::t_cmd  i_cmd,
    input  wire logic          i_pop,
    output tw_pkg::t_cmd       o_cmd,
    output tw_pkg::t_q_status  o_status
);

    tw_pkg::t_cmd                    r_mem [tw_pkg::QUEUE_DEPTH];
    logic [tw_pkg::QUEUE_AW-1:0]     r_wr;
    logic [tw_pkg::QUEUE_AW-1:0]     r_rd;
    logic [tw_pkg::QUEUE_CNT_W-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + tw_pkg::QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + tw_pkg::QUEUE_AW'(1);
            end
            r_cnt <= r_cnt + tw_pkg::QUEUE_CNT_W'(i_push) - tw_pkg::QUEUE_CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_cmd          = r_mem[r_rd];
    assign o_status.full  = (r_cnt == tw_pkg::QUEUE_CNT_W'(tw_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);

endmodule

`default_nettype wire

>>> rtl/tw_back.sv
`default_nettype none

module tw_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tw_pkg::t_cfg      i_cfg,
    input  wire tw_pkg::t_cmd      i_cmd,
    input  wire tw_pkg::t_q_status i_qs,
    input  wire logic              i_load_ok,
    output logic                   o_pop,
    output logic                   o_load,
    output tw_pkg::t_frame         o_frame
);

    localparam int IDX_PROD_W = 30 + tw_pkg::SINE_ADDR_W;

    function automatic logic signed [tw_pkg::WAVE_W-1:0] shr_trunc(
        input logic signed [tw_pkg::TRI_W-1:0] v,
        input int unsigned                     sh
    );
        logic signed [tw_pkg::TRI_W-1:0] bias;
        logic signed [tw_pkg::TRI_W-1:0] r;
        bias = signed'((tw_pkg::TRI_W'(1) << sh) - tw_pkg::TRI_W'(1));
        r    = (v < 0) ? ((v + bias) >>> sh) : (v >>> sh);
        return tw_pkg::WAVE_W'(r);
    endfunction

    logic                              w_en;
    logic [31:0]                       w_q;
    logic [IDX_PROD_W-1:0]             w_idx_prod;
    logic [tw_pkg::SINE_ADDR_W-1:0]    w_idx;
    logic [tw_pkg::SINE_ADDR_W-1:0]    w_addr;
    logic signed [tw_pkg::TRI_W-1:0]   w_tq;
    logic signed [tw_pkg::WAVE_W-1:0]  w_wave;
    logic signed [tw_pkg::PROD_W-1:0]  w_rnd;
    logic signed [tw_pkg::PROD_W-1:0]  w_quot;
    logic signed [tw_pkg::SAMPLE_W-1:0] w_sample;
    logic [tw_pkg::COUNT_W-1:0]        w_count;

    logic [tw_pkg::PHASE_BITS-1:0]     r_phase;
    logic                              r1_valid;
    logic [31:0]                       r1_q;
    logic [tw_pkg::SINE_ADDR_W-1:0]    r1_addr;
    logic                              r2_valid;
    logic [31:0]                       r2_q;
    logic [tw_pkg::ROM_W-1:0]          r2_rom;
    logic                              r3_valid;
    logic signed [tw_pkg::WAVE_W-1:0]  r3_w;
    logic                              r4_valid;
    logic signed [tw_pkg::PROD_W-1:0]  r4_p;

    // Advance the whole pipe unless a finished sample waits on the output
    assign w_en  = !r4_valid || i_load_ok;
    assign o_pop = w_en && !i_qs.empty;

    assign w_q        = 32'((64'(r_phase) << tw_pkg::Q_SHL) >> tw_pkg::Q_SHR);
    assign w_idx_prod = IDX_PROD_W'(w_q[29:0]) * IDX_PROD_W'(tw_pkg::SINE_DEPTH);
    assign w_idx      = w_idx_prod[IDX_PROD_W-1:30];
    // Odd quadrants read the table backwards
    assign w_addr     = w_q[30] ? (tw_pkg::SINE_ADDR_W'(tw_pkg::SINE_DEPTH) - w_idx) : w_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= o_pop && (i_cmd.kind == tw_pkg::REQ_TICK);
            if (o_pop) begin
                if (i_cmd.kind == tw_pkg::REQ_TICK) begin
                    r_phase  <= r_phase + i_cfg.phase_inc;
                end else begin
                    r_phase  <= i_cmd.seek_phase;
                end
            end
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_q    <= w_q;
            r1_addr <= w_addr;
            r2_q    <= r1_q;
            r2_rom  <= tw_pkg::SINE_ROM[r1_addr];
            r3_w    <= w_wave;
            r4_p    <= tw_pkg::PROD_W'(r3_w)
                       * tw_pkg::PROD_W'(signed'({1'b0, i_cfg.gain}));
        end
    end

    assign w_tq = signed'({2'b00, r2_q});

    always_comb begin
        case (i_cfg.wave)
            tw_pkg::WAVE_SINE: begin
                w_wave = r2_q[31] ? -signed'(r2_rom) : signed'(r2_rom);
            end
            tw_pkg::WAVE_SQUARE: begin
                w_wave = (r2_q <= 32'h8000_0000) ? 17'sd32768 : -17'sd32768;
            end
            tw_pkg::WAVE_TRIANGLE: begin
                if (r2_q <= 32'h4000_0000) begin
                    w_wave = shr_trunc(w_tq, 15);
                end else if (r2_q <= 32'hC000_0000) begin
                    w_wave = shr_trunc(34'sd2147483648 - w_tq, 15);
                end else begin
                    w_wave = shr_trunc(w_tq - 34'sd4294967296, 15);
                end
            end
            tw_pkg::WAVE_SAW: begin
                w_wave = shr_trunc(w_tq - 34'sd2147483648, 16);
            end
            default: begin
                w_wave = '0;
            end
        endcase
    end

    // Round half up, truncate toward zero, clamp to int16
    assign w_rnd  = r4_p + 34'sd8192;
    assign w_quot = (w_rnd < 0) ? ((w_rnd + 34'sd16383) >>> 14) : (w_rnd >>> 14);

    always_comb begin
        if (r4_p <= -34'sd536870912) begin
            w_sample = -16'sd32768;
        end else if (r4_p >= 34'sd536854528) begin
            w_sample = 16'sd32767;
        end else begin
            w_sample = tw_pkg::SAMPLE_W'(w_quot);
        end
    end

    assign w_count = (i_cfg.chan_count > tw_pkg::COUNT_W'(tw_pkg::CH_LIMIT))
                   ? tw_pkg::COUNT_W'(tw_pkg::CH_LIMIT) : i_cfg.chan_count;

    // A frame with no channels is dropped here
    assign o_load           = r4_valid && i_load_ok && (w_count != '0);
    assign o_frame.sample   = w_sample;
    assign o_frame.last_idx = tw_pkg::CH_W'(w_count - tw_pkg::COUNT_W'(1));

endmodule

`default_nettype wire

>>> rtl/tw_emit.sv
`default_nettype none

module tw_emit (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire tw_pkg::t_frame  i_frame,
    output logic                 o_load_ok,
    tw_out_if.source             o_out
);

    logic                               r_valid;
    logic signed [tw_pkg::SAMPLE_W-1:0] r_sample;
    logic [tw_pkg::CH_W-1:0]            r_channel;
    logic [tw_pkg::CH_W-1:0]            r_last_idx;
    logic                               w_last;
    logic                               w_xfer;

    assign w_last    = (r_channel == r_last_idx);
    assign w_xfer    = r_valid && o_out.ready;
    assign o_load_ok = !r_valid || (o_out.ready && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (w_xfer && w_last) begin
            r_valid <= 1'b0;
        end
    end

    // Hold the sample and step the channel after each transfer but the last
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sample   <= i_frame.sample;
            r_channel  <= '0;
            r_last_idx <= i_frame.last_idx;
        end else if (w_xfer && !w_last) begin
            r_channel  <= r_channel + tw_pkg::CH_W'(1);
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.sample       = r_sample;
    assign o_out.channel      = r_channel;
    assign o_out.last_channel = w_last;

endmodule

`default_nettype wire

>>> rtl/tone_waveform_generator_top.sv
// Latency: a tick passes through the command queue, pipeline stages r1 to r4 and the
//   output register before its first channel copy is offered; a seek updates the phase when popped.
// Throughput: ticks are paced by the output register, which presents one channel copy per cycle
//   while the sink is ready, min(channel_count, 8) copies per tick; a seek yields no sample.
// Reset (synchronous, active low) clears phase, command queue, pipeline and output;
//   configuration registers return to defaults. The sine table is constant.
`default_nettype none

module tone_waveform_generator_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    tw_in_if.sink                                 i_in,
    tw_out_if.source                              o_out,
    input  wire logic                             i_cfg_we,
    input  wire logic [tw_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [tw_pkg::CFG_W-1:0]         i_cfg_wdata
);

    tw_pkg::t_cfg       r_cfg;
    tw_pkg::t_cmd       w_push_cmd;
    tw_pkg::t_cmd       w_head_cmd;
    tw_pkg::t_q_status  w_qs;
    tw_pkg::t_frame     w_frame;
    logic               w_push;
    logic               w_pop;
    logic               w_load;
    logic               w_load_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_inc  <= tw_pkg::PHASE_BITS'(tw_pkg::PHASE_INC_RESET);
            r_cfg.wave       <= tw_pkg::WAVE_SINE;
            r_cfg.gain       <= tw_pkg::GAIN_RESET;
            r_cfg.chan_count <= tw_pkg::CHANNELS_RESET;
        end else if (i_cfg_we) begin
            case (tw_pkg::t_cfg_idx'(i_cfg_idx))
                tw_pkg::CFG_PHASE_INC: begin
                    r_cfg.phase_inc <= tw_pkg::PHASE_BITS'(i_cfg_wdata);
                end
                tw_pkg::CFG_WAVEFORM: begin
                    r_cfg.wave <= tw_pkg::t_wave'(i_cfg_wdata[1:0]);
                end
                tw_pkg::CFG_LEVEL_GAIN: begin
                    r_cfg.gain <= i_cfg_wdata[tw_pkg::GAIN_W-1:0];
                end
                tw_pkg::CFG_CHANNELS: begin
                    r_cfg.chan_count <= i_cfg_wdata[tw_pkg::COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    tw_front u_front (
        .i_in        (i_in),
        .i_phase_inc (r_cfg.phase_inc),
        .i_qs        (w_qs),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    tw_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .i_pop    (w_pop),
        .o_cmd    (w_head_cmd),
        .o_status (w_qs)
    );

    tw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_cmd     (w_head_cmd),
        .i_qs      (w_qs),
        .i_load_ok (w_load_ok),
        .o_pop     (w_pop),
        .o_load    (w_load),
        .o_frame   (w_frame)
    );

    tw_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_load),
        .i_frame   (w_frame),
        .o_load_ok (w_load_ok),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire
